// ----- rtl/core/rc_channel_normalizer_top_macros.svh -----
// Assertion helpers for the RC channel normalizer.
// Define ASSERT_OFF to compile the checks out.
`ifndef RC_CHANNEL_NORMALIZER_TOP_MACROS_SVH
`define RC_CHANNEL_NORMALIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define RCN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define RCN_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RCN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define RCN_ASSERT(lbl, clk, rstn, prop, msg)
`define RCN_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RCN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/core/rcn_pkg.sv -----
package rcn_pkg;

    // channel numbering
    localparam int unsigned CHANNELS = 18;
    localparam int unsigned REV_BITS = 18;

    // calibration limits
    localparam logic [11:0] RAW_CAP = 12'd4000;
    localparam logic [6:0]  PCT_CAP = 7'd100;

    // divider: 15 quotient bits, q = num * 2^15 / den with num < den
    localparam int unsigned DIV_STEPS = 15;
    localparam logic [15:0] Q_FULL_SCALE = 16'd32768;
    localparam logic [16:0] Q_HALF_SCALE = 17'd16384;
    localparam logic [22:0] PCT_SCALE    = 23'd100;

    // input action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // config register indexes
    localparam logic [2:0] CFG_MIN_RAW   = 3'd0;
    localparam logic [2:0] CFG_MAX_RAW   = 3'd1;
    localparam logic [2:0] CFG_DEAD_ZONE = 3'd2;
    localparam logic [2:0] CFG_REV_MASK  = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd4;

    // config reset values
    localparam logic [11:0] RST_MIN_RAW   = 12'd240;
    localparam logic [11:0] RST_MAX_RAW   = 12'd1807;
    localparam logic [6:0]  RST_DEAD_ZONE = 7'd5;
    localparam logic [17:0] RST_REV_MASK  = 18'd0;
    localparam logic [15:0] RST_TIMEOUT   = 16'd100;
    localparam logic [7:0]  RST_RSSI      = 8'd255;

    // how the back end gets the quotient
    localparam logic [1:0] OP_ZERO  = 2'd0;  // raw at or below min
    localparam logic [1:0] OP_FULL  = 2'd1;  // raw at or above max
    localparam logic [1:0] OP_DIV   = 2'd2;  // raw inside the span
    localparam logic [1:0] OP_EMPTY = 2'd3;  // max not above min

    typedef struct packed {
        logic        norm;     // carries a channel value
        logic [1:0]  op;
        logic [4:0]  ch;
        logic [11:0] num;      // raw - min
        logic [11:0] den;      // max - min
        logic        rev;
        logic [6:0]  pct;
        logic        link_ok;
        logic [7:0]  rssi;
        logic [4:0]  count;
    } t_job;

endpackage

// ----- rtl/core/rcn_front.sv -----
`include "rc_channel_normalizer_top_macros.svh"

module rcn_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [17:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_action,
    input  logic [4:0]          i_channel_index,
    input  logic [11:0]         i_raw_value,
    input  logic [7:0]          i_rssi_in,
    input  logic                i_signal_available,
    input  logic                i_last_of_frame,
    input  logic                i_queue_full,
    output logic                o_in_ready,
    output logic                o_push,
    output rcn_pkg::t_job       o_job
);

    logic [11:0] r_min_raw;
    logic [11:0] r_max_raw;
    logic [6:0]  r_dead_zone;
    logic [17:0] r_rev_mask;
    logic [15:0] r_timeout;

    logic [15:0] r_silence, n_silence;
    logic        r_link, n_link;
    logic [7:0]  r_rssi, n_rssi;
    logic [4:0]  r_count, n_count;

    logic        accept;
    logic [11:0] lo, hi;
    logic [6:0]  pct;
    logic [15:0] sil_inc;
    logic [5:0]  ch_p1;
    logic [31:0] mask_ext;
    logic        ch_ok;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept;

    always_comb begin
        lo       = (r_min_raw > rcn_pkg::RAW_CAP) ? rcn_pkg::RAW_CAP : r_min_raw;
        hi       = (r_max_raw > rcn_pkg::RAW_CAP) ? rcn_pkg::RAW_CAP : r_max_raw;
        pct      = (r_dead_zone > rcn_pkg::PCT_CAP) ? rcn_pkg::PCT_CAP : r_dead_zone;
        sil_inc  = (r_silence == '1) ? r_silence : r_silence + 16'd1;
        ch_p1    = {1'b0, i_channel_index} + 6'd1;
        mask_ext = {{(32 - rcn_pkg::REV_BITS){1'b0}}, r_rev_mask};
        ch_ok    = {1'b0, i_channel_index} < 6'(rcn_pkg::CHANNELS);

        n_silence = r_silence;
        n_link    = r_link;
        n_rssi    = r_rssi;
        n_count   = r_count;
        priority if (i_action == rcn_pkg::ACT_TICK) begin
            n_silence = sil_inc;
            if (sil_inc > r_timeout) begin
                n_link = 1'b0;
            end
        end else if (i_signal_available) begin
            n_link    = 1'b1;
            n_silence = '0;
            n_rssi    = i_rssi_in;
            if (i_last_of_frame) begin
                n_count = (ch_p1 > 6'(rcn_pkg::CHANNELS)) ?
                          5'(rcn_pkg::CHANNELS) : ch_p1[4:0];
            end
        end

        o_job.norm    = (i_action == rcn_pkg::ACT_SAMPLE) && i_signal_available && ch_ok;
        o_job.ch      = i_channel_index;
        o_job.num     = i_raw_value - lo;
        o_job.den     = hi - lo;
        o_job.rev     = mask_ext[i_channel_index];
        o_job.pct     = pct;
        o_job.link_ok = n_link;
        o_job.rssi    = n_rssi;
        o_job.count   = n_count;
        priority if (hi <= lo) begin
            o_job.op = rcn_pkg::OP_EMPTY;
        end else if (i_raw_value <= lo) begin
            o_job.op = rcn_pkg::OP_ZERO;
        end else if (i_raw_value >= hi) begin
            o_job.op = rcn_pkg::OP_FULL;
        end else begin
            o_job.op = rcn_pkg::OP_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_raw   <= rcn_pkg::RST_MIN_RAW;
            r_max_raw   <= rcn_pkg::RST_MAX_RAW;
            r_dead_zone <= rcn_pkg::RST_DEAD_ZONE;
            r_rev_mask  <= rcn_pkg::RST_REV_MASK;
            r_timeout   <= rcn_pkg::RST_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rcn_pkg::CFG_MIN_RAW:   r_min_raw   <= i_cfg_data[11:0];
                rcn_pkg::CFG_MAX_RAW:   r_max_raw   <= i_cfg_data[11:0];
                rcn_pkg::CFG_DEAD_ZONE: r_dead_zone <= i_cfg_data[6:0];
                rcn_pkg::CFG_REV_MASK:  r_rev_mask  <= i_cfg_data;
                rcn_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= '0;
            r_link    <= 1'b0;
            r_rssi    <= rcn_pkg::RST_RSSI;
            r_count   <= '0;
        end else if (accept) begin
            r_silence <= n_silence;
            r_link    <= n_link;
            r_rssi    <= n_rssi;
            r_count   <= n_count;
        end
    end

    // a tick always leaves a nonzero silence count behind
    `RCN_ASSERT_NEXT(a_tick_counts, i_clk, i_rst_n, accept && i_action == rcn_pkg::ACT_TICK, r_silence != 16'd0, "tick did not advance silence count")

endmodule

// ----- rtl/core/rcn_queue.sv -----
`include "rc_channel_normalizer_top_macros.svh"

module rcn_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcn_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rcn_pkg::t_job  o_job
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rcn_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `RCN_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `RCN_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")

endmodule

// ----- rtl/core/rcn_back.sv -----
`include "rc_channel_normalizer_top_macros.svh"

module rcn_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  rcn_pkg::t_job        i_job,
    output logic                 o_pop,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_valid_res,
    output logic [4:0]           o_channel_out,
    output logic signed [15:0]   o_normalized,
    output logic                 o_in_dead_zone,
    output logic                 o_link_ok,
    output logic [7:0]           o_rssi_out,
    output logic [4:0]           o_channel_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_NORM = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state;
    rcn_pkg::t_job r_job;
    logic [11:0]   r_rem;
    logic [15:0]   r_q;
    logic [3:0]    r_cnt;
    logic [15:0]   r_norm;

    logic          r_out_valid;
    logic          r_valid_res;
    logic [4:0]    r_channel_out;
    logic [15:0]   r_normalized;
    logic          r_in_dead_zone;
    logic          r_link_ok;
    logic [7:0]    r_rssi_out;
    logic [4:0]    r_channel_count;

    logic [12:0]   rem2;
    logic          rem_ge;
    logic [15:0]   mag;
    logic [22:0]   mag_x100;
    logic [22:0]   dz_limit;
    logic          dz_hit;
    logic          load_out;

    assign o_pop    = (r_state == S_IDLE) && i_job_valid;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        rem2     = {r_rem, 1'b0};
        rem_ge   = rem2 >= {1'b0, r_job.den};
        mag      = r_norm[15] ? (~r_norm + 16'd1) : r_norm;
        mag_x100 = 23'(mag) * rcn_pkg::PCT_SCALE;
        dz_limit = {2'b00, r_job.pct, 14'd0};
        dz_hit   = mag_x100 <= dz_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_rem <= i_job.num;
                        r_cnt <= '0;
                        r_q   <= (i_job.op == rcn_pkg::OP_FULL) ? rcn_pkg::Q_FULL_SCALE : '0;
                        priority if (!i_job.norm) begin
                            r_state <= S_DONE;
                        end else if (i_job.op == rcn_pkg::OP_DIV) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= rem_ge ? 12'(rem2 - {1'b0, r_job.den}) : rem2[11:0];
                    r_q   <= {r_q[14:0], rem_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(rcn_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    priority if (r_job.op == rcn_pkg::OP_EMPTY) begin
                        r_norm <= '0;
                    end else if (r_job.rev) begin
                        r_norm <= 16'(rcn_pkg::Q_HALF_SCALE - {1'b0, r_q});
                    end else begin
                        r_norm <= 16'({1'b0, r_q} - rcn_pkg::Q_HALF_SCALE);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_valid_res     <= r_job.norm;
            r_channel_out   <= r_job.norm ? r_job.ch : '0;
            r_normalized    <= r_job.norm ? r_norm : '0;
            r_in_dead_zone  <= r_job.norm && dz_hit;
            r_link_ok       <= r_job.link_ok;
            r_rssi_out      <= r_job.rssi;
            r_channel_count <= r_job.count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_valid_res     = r_valid_res;
    assign o_channel_out   = r_channel_out;
    assign o_normalized    = $signed(r_normalized);
    assign o_in_dead_zone  = r_in_dead_zone;
    assign o_link_ok       = r_link_ok;
    assign o_rssi_out      = r_rssi_out;
    assign o_channel_count = r_channel_count;

    `RCN_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_job.den, "divider remainder out of range")
    `RCN_ASSERT_IMPL(a_norm_range, i_clk, i_rst_n, o_out_valid && o_valid_res, o_normalized <= 16'sd16384 && o_normalized >= -16'sd16384, "normalized value out of range")
    `RCN_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != S_IDLE, "job taken but back end stayed idle")

endmodule

// ----- rtl/core/rc_channel_normalizer_top.sv -----
// RC channel normalizer. Every transaction on the input channel is either a
// decoded channel sample or one time tick, and yields exactly one result
// transaction, in order. A sample with signal available is calibrated against
// min_raw/max_raw (both capped at 4000), clamped, optionally reversed per the
// channel's bit in reverse_mask and mapped to a signed Q2.14 value in
// -16384..16384; in_dead_zone flags a magnitude within dead_zone_pct percent
// (capped at 100). Ticks, samples without signal and samples on channels at or
// above CHANNELS give valid_res = 0 with zero value fields; link_ok, rssi_out
// and channel_count always show the link state right after that transaction.
// The link drops when the saturating silence counter passes
// loss_timeout_ticks. Timing: the front end takes one transaction per cycle
// while the queue is not full into a QUEUE_DEPTH-entry queue (range 2 and
// up) and updates link state at once. The back end runs a restoring
// divider that makes one quotient bit per cycle, so a sample whose raw
// value lies strictly inside the span goes through the idle, divide,
// normalize and done states; a sample clamped to an end or with an empty
// span skips the divide, and any other transaction goes from idle straight
// to done. A result waits in an output register while the back end starts
// on the next queued job.
// Configuration writes are always taken (o_cfg_ready is tied high); indexes
// 0..4 select min_raw, max_raw, dead_zone_pct, reverse_mask and
// loss_timeout_ticks, other indexes are ignored. Write them only while the
// block is idle. Reset (i_rst_n low, synchronous) restores 240, 1807, 5, 0
// and 100, clears the link and sets the latched RSSI to 255.
module rc_channel_normalizer_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [17:0]         i_cfg_data,

    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_action,
    input  logic [4:0]          i_channel_index,
    input  logic [11:0]         i_raw_value,
    input  logic [7:0]          i_rssi_in,
    input  logic                i_signal_available,
    input  logic                i_last_of_frame,

    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_valid_res,
    output logic [4:0]          o_channel_out,
    output logic signed [15:0]  o_normalized,
    output logic                o_in_dead_zone,
    output logic                o_link_ok,
    output logic [7:0]          o_rssi_out,
    output logic [4:0]          o_channel_count
);

    rcn_pkg::t_job push_job;
    rcn_pkg::t_job head_job;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    assign o_cfg_ready = 1'b1;

    // front end: config registers, link state, sample classification
    rcn_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_action           (i_action),
        .i_channel_index    (i_channel_index),
        .i_raw_value        (i_raw_value),
        .i_rssi_in          (i_rssi_in),
        .i_signal_available (i_signal_available),
        .i_last_of_frame    (i_last_of_frame),
        .i_queue_full       (q_full),
        .o_in_ready         (o_in_ready),
        .o_push             (push),
        .o_job              (push_job)
    );

    // decouples intake from the multi-cycle divide
    rcn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // back end: divider, Q2.14 mapping, dead zone, output register
    rcn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (!q_empty),
        .i_job           (head_job),
        .o_pop           (pop),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_valid_res     (o_valid_res),
        .o_channel_out   (o_channel_out),
        .o_normalized    (o_normalized),
        .o_in_dead_zone  (o_in_dead_zone),
        .o_link_ok       (o_link_ok),
        .o_rssi_out      (o_rssi_out),
        .o_channel_count (o_channel_count)
    );

endmodule

// ----- tb/sv/rc_channel_normalizer_top_tb.sv -----
`timescale 1ns / 1ps

module rc_channel_normalizer_top_tb;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned MAX_WAIT      = 5;     // longest idle draw per transaction
    localparam int unsigned SETTLE_CYCLES = 24;    // one full divide job plus the output register
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned PHASE_ITEMS   = 145;
    localparam int unsigned SOAK_TICKS    = 16;    // silent ticks under the largest timeout
    localparam logic [2:0]  CFG_UNUSED    = 3'd7;  // not a register, write is dropped
    localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

    // One input transaction and one result transaction, in port order.
    typedef struct packed {
        logic        action;
        logic [4:0]  ch;
        logic [11:0] raw;
        logic [7:0]  rssi;
        logic        avail;
        logic        last;
    } t_rc_item;

    typedef struct packed {
        logic               valid_res;
        logic [4:0]         channel;
        logic signed [15:0] position;
        logic               dead_zone;
        logic               link_ok;
        logic [7:0]         rssi;
        logic [4:0]         count;
    } t_rc_result;

    // Scoreboard: keeps its own copy of the registers and the link state,
    // computes the calibrated position for each accepted transaction and
    // matches results in order.
    class rcn_scoreboard;
        logic [11:0] min_raw;
        logic [11:0] max_raw;
        logic [6:0]  dz_pct;
        logic [17:0] rev_mask;
        logic [15:0] loss_timeout;
        logic [15:0] silence;
        logic        link_good;
        logic [7:0]  rssi_latch;
        logic [4:0]  frame_count;
        t_rc_result  expected_positions[$];
        int unsigned errors;

        function new();
            min_raw      = rcn_pkg::RST_MIN_RAW;
            max_raw      = rcn_pkg::RST_MAX_RAW;
            dz_pct       = rcn_pkg::RST_DEAD_ZONE;
            rev_mask     = rcn_pkg::RST_REV_MASK;
            loss_timeout = rcn_pkg::RST_TIMEOUT;
            silence      = '0;
            link_good    = 1'b0;
            rssi_latch   = rcn_pkg::RST_RSSI;
            frame_count  = '0;
            errors       = 0;
        endfunction

        function int unsigned pending();
            return expected_positions.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [17:0] data);
            case (idx)
                rcn_pkg::CFG_MIN_RAW:   min_raw      = data[11:0];
                rcn_pkg::CFG_MAX_RAW:   max_raw      = data[11:0];
                rcn_pkg::CFG_DEAD_ZONE: dz_pct       = data[6:0];
                rcn_pkg::CFG_REV_MASK:  rev_mask     = data;
                rcn_pkg::CFG_TIMEOUT:   loss_timeout = data[15:0];
                default: ;
            endcase
        endfunction

        function void predict_position(t_rc_item smp);
            t_rc_result  res;
            int unsigned lo;
            int unsigned hi;
            int unsigned pct;
            int unsigned raw;
            int unsigned q;
            int unsigned mag;
            int unsigned n;
            int          pos;
            logic        rev;
            res = '0;
            if (smp.action == rcn_pkg::ACT_TICK) begin
                if (silence != SILENCE_MAX) silence = silence + 16'd1;
                if (silence > loss_timeout) link_good = 1'b0;
            end else if (smp.avail) begin
                link_good  = 1'b1;
                silence    = '0;
                rssi_latch = smp.rssi;
                if (smp.last) begin
                    n = smp.ch + 1;
                    if (n > rcn_pkg::CHANNELS) n = rcn_pkg::CHANNELS;
                    frame_count = n[4:0];
                end
                if (smp.ch < rcn_pkg::CHANNELS) begin
                    lo  = (min_raw > rcn_pkg::RAW_CAP) ? rcn_pkg::RAW_CAP : min_raw;
                    hi  = (max_raw > rcn_pkg::RAW_CAP) ? rcn_pkg::RAW_CAP : max_raw;
                    pct = (dz_pct > rcn_pkg::PCT_CAP) ? rcn_pkg::PCT_CAP : dz_pct;
                    raw = smp.raw;
                    pos = 0;
                    if (hi > lo) begin
                        if (raw <= lo)
                            q = 0;
                        else if (raw >= hi)
                            q = rcn_pkg::Q_FULL_SCALE;
                        else
                            q = ((raw - lo) * rcn_pkg::Q_FULL_SCALE) / (hi - lo);
                        rev = 1'b0;
                        if (smp.ch < rcn_pkg::REV_BITS) rev = rev_mask[smp.ch];
                        pos = rev ? (rcn_pkg::Q_HALF_SCALE - q) : (q - rcn_pkg::Q_HALF_SCALE);
                    end
                    mag = (pos < 0) ? -pos : pos;
                    res.valid_res = 1'b1;
                    res.channel   = smp.ch;
                    res.position  = pos[15:0];
                    res.dead_zone = (mag * rcn_pkg::PCT_SCALE) <= (pct * rcn_pkg::Q_HALF_SCALE);
                end
            end
            res.link_ok = link_good;
            res.rssi    = rssi_latch;
            res.count   = frame_count;
            expected_positions.push_back(res);
        endfunction

        function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        endfunction

        function void check_result(t_rc_result got);
            t_rc_result want;
            if (expected_positions.size() == 0) begin
                $error("result transaction with nothing outstanding: channel %0d position %0d",
                       got.channel, got.position);
                errors++;
                return;
            end
            want = expected_positions.pop_front();
            if (got.valid_res !== want.valid_res)
                report("valid_res", want.valid_res, got.valid_res);
            if (got.channel !== want.channel)
                report("channel_out", want.channel, got.channel);
            if (got.position !== want.position)
                report("normalized", $signed(want.position), $signed(got.position));
            if (got.dead_zone !== want.dead_zone)
                report("in_dead_zone", want.dead_zone, got.dead_zone);
            if (got.link_ok !== want.link_ok)
                report("link_ok", want.link_ok, got.link_ok);
            if (got.rssi !== want.rssi)
                report("rssi_out", want.rssi, got.rssi);
            if (got.count !== want.count)
                report("channel_count", want.count, got.count);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [17:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    logic [4:0]         i_channel_index;
    logic [11:0]        i_raw_value;
    logic [7:0]         i_rssi_in;
    logic               i_signal_available;
    logic               i_last_of_frame;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_valid_res;
    logic [4:0]         o_channel_out;
    logic signed [15:0] o_normalized;
    logic               o_in_dead_zone;
    logic               o_link_ok;
    logic [7:0]         o_rssi_out;
    logic [4:0]         o_channel_count;

    rcn_scoreboard sb;
    bit            in_gaps_on;     // sender draws idle cycles per transaction
    bit            out_stalls_on;  // receiver draws stall cycles per result
    int unsigned   idle_cycles;

    rc_channel_normalizer_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_channel_index    (i_channel_index),
        .i_raw_value        (i_raw_value),
        .i_rssi_in          (i_rssi_in),
        .i_signal_available (i_signal_available),
        .i_last_of_frame    (i_last_of_frame),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_valid_res        (o_valid_res),
        .o_channel_out      (o_channel_out),
        .o_normalized       (o_normalized),
        .o_in_dead_zone     (o_in_dead_zone),
        .o_link_ok          (o_link_ok),
        .o_rssi_out         (o_rssi_out),
        .o_channel_count    (o_channel_count)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Monitor: every handshake is sampled at the rising edge, before the
    // design's registers move. Config writes only happen while idle, so
    // they never share an edge with a sample transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result({o_valid_res, o_channel_out, o_normalized, o_in_dead_zone,
                                 o_link_ok, o_rssi_out, o_channel_count});
            if (i_in_valid && o_in_ready)
                sb.predict_position({i_action, i_channel_index, i_raw_value, i_rssi_in,
                                     i_signal_available, i_last_of_frame});
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);

            // watchdog: any transaction on any channel counts as progress
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rc_channel_normalizer_top_tb: FAIL");
                $finish;
            end
        end
    end

    // Result sink: ready drops for a random number of cycles before each
    // result, then stays up until a result is taken.
    initial begin : result_sink
        int unsigned stall;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = out_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid === 1'b1));
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still
    // high, so back-to-back transactions keep valid asserted.
    task automatic push_item(t_rc_item smp);
        int unsigned gap;
        gap = in_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action           <= smp.action;
        i_channel_index    <= smp.ch;
        i_raw_value        <= smp.raw;
        i_rssi_in          <= smp.rssi;
        i_signal_available <= smp.avail;
        i_last_of_frame    <= smp.last;
        i_in_valid         <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [17:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Upper data bits beyond each register's width carry junk on purpose.
    task automatic configure(logic [11:0] mn, logic [11:0] mx, logic [6:0] dz,
                             logic [17:0] rev, logic [15:0] tmo);
        write_reg(rcn_pkg::CFG_MIN_RAW,   {6'($urandom), mn});
        write_reg(rcn_pkg::CFG_MAX_RAW,   {6'($urandom), mx});
        write_reg(rcn_pkg::CFG_DEAD_ZONE, {11'($urandom), dz});
        write_reg(rcn_pkg::CFG_REV_MASK,  rev);
        write_reg(rcn_pkg::CFG_TIMEOUT,   {2'($urandom), tmo});
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding result, then let the back end
    // run dry before touching the registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_rc_item make_sample(logic [4:0] ch, logic [11:0] raw,
                                             logic [7:0] rssi, logic avail, logic last);
        t_rc_item smp;
        smp.action = rcn_pkg::ACT_SAMPLE;
        smp.ch     = ch;
        smp.raw    = raw;
        smp.rssi   = rssi;
        smp.avail  = avail;
        smp.last   = last;
        return smp;
    endfunction

    // Tick payload is don't-care, so it is random.
    function automatic t_rc_item make_tick();
        t_rc_item smp;
        smp        = t_rc_item'($urandom);
        smp.action = rcn_pkg::ACT_TICK;
        return smp;
    endfunction

    // Raw values cluster on the calibration points and inside the span.
    function automatic logic [11:0] pick_raw();
        logic [11:0] lo;
        logic [11:0] hi;
        lo = (sb.min_raw > rcn_pkg::RAW_CAP) ? rcn_pkg::RAW_CAP : sb.min_raw;
        hi = (sb.max_raw > rcn_pkg::RAW_CAP) ? rcn_pkg::RAW_CAP : sb.max_raw;
        case ($urandom_range(0, 11))
            0: return 12'd0;
            1: return 12'hFFF;
            2: return lo;
            3: return hi;
            4: return lo + 12'd1;
            5: return hi - 12'd1;
            6: return 12'($urandom);
            default: begin
                if (hi > lo) return 12'($urandom_range(lo, hi));
                return 12'($urandom);
            end
        endcase
    endfunction

    // One receiver frame: channels 0..n-1 in order, last flag on the final one.
    task automatic send_frame(output int unsigned n);
        logic [7:0] rssi;
        n    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, rcn_pkg::CHANNELS)
                                           : rcn_pkg::CHANNELS;
        rssi = 8'($urandom);
        for (int unsigned c = 0; c < n; c++)
            push_item(make_sample(c[4:0], pick_raw(), rssi, 1'b1, c == n - 1));
    endtask

    task automatic run_random(int unsigned target);
        int unsigned done_items;
        int unsigned n;
        int unsigned kind;
        done_items = 0;
        while (done_items < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                send_frame(n);
                done_items += n;
            end else if (kind < 72) begin
                // tick bursts to walk the silence counter past short timeouts
                n = $urandom_range(1, 8);
                repeat (n) push_item(make_tick());
                done_items += n;
            end else if (kind < 82) begin
                // no signal: changes nothing, not counted
                push_item(make_sample(5'($urandom), 12'($urandom), 8'($urandom), 1'b0,
                                      1'($urandom)));
            end else begin
                // any channel number, including those past the last one
                push_item(make_sample(5'($urandom), pick_raw(), 8'($urandom), 1'b1,
                                      1'($urandom)));
                done_items++;
            end
        end
    endtask

    initial begin : stimulus
        logic [11:0] mn;
        logic [11:0] mx;
        sb = new();
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = rcn_pkg::CFG_MIN_RAW;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_action           = rcn_pkg::ACT_SAMPLE;
        i_channel_index    = '0;
        i_raw_value        = '0;
        i_rssi_in          = '0;
        i_signal_available = 1'b0;
        i_last_of_frame    = 1'b0;
        in_gaps_on         = 1'b1;
        out_stalls_on      = 1'b1;
        idle_cycles        = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset calibration (240..1807, 5 %, no reversal, 100 ticks).
        push_item(make_tick());                                    // tick with link down
        push_item(make_sample(5'd0,  12'd0,    8'd0,   1'b1, 1'b0)); // clamp low
        push_item(make_sample(5'd17, 12'hFFF,  8'hFF,  1'b1, 1'b1)); // clamp high, full frame
        push_item(make_sample(5'd1,  12'd240,  8'h11,  1'b1, 1'b0)); // exactly min
        push_item(make_sample(5'd2,  12'd1807, 8'h22,  1'b1, 1'b0)); // exactly max
        push_item(make_sample(5'd3,  12'd241,  8'h33,  1'b1, 1'b0)); // just inside
        push_item(make_sample(5'd4,  12'd1806, 8'h44,  1'b1, 1'b0));
        push_item(make_sample(5'd5,  12'd1023, 8'h55,  1'b1, 1'b0)); // near center
        push_item(make_sample(5'd6,  12'd1024, 8'h66,  1'b1, 1'b0));
        push_item(make_sample(5'd7,  12'hFFF,  8'h5A,  1'b0, 1'b1)); // no signal
        push_item(make_sample(5'd18, 12'd1000, 8'hA5,  1'b1, 1'b1)); // past last channel
        push_item(make_sample(5'd31, 12'hFFF,  8'h3C,  1'b1, 1'b1)); // count stays 18
        push_item(make_sample(5'd15, 12'd1100, 8'h77,  1'b1, 1'b1)); // short frame
        push_item(make_tick());

        // Full range, every channel reversed, zero dead zone, zero timeout.
        settle();
        configure(12'd0, 12'd4000, 7'd0, 18'h3FFFF, 16'd0);
        push_item(make_tick());                                    // first tick drops link
        push_item(make_sample(5'd0,  12'd0,    8'h01, 1'b1, 1'b0));
        push_item(make_sample(5'd9,  12'd4000, 8'h02, 1'b1, 1'b0));
        push_item(make_sample(5'd17, 12'd2000, 8'h03, 1'b1, 1'b0)); // dead center
        push_item(make_sample(5'd20, 12'd2000, 8'h04, 1'b1, 1'b1)); // never reversed

        // Both ends above the cap: empty span; dead zone above the cap.
        settle();
        configure(12'hFFF, 12'hFFF, 7'h7F, 18'($urandom), 16'hFFFF);
        push_item(make_sample(5'd3, 12'd0, 8'h05, 1'b1, 1'b0));

        // max below min, one-tick timeout, plus a write to an unmapped index.
        settle();
        configure(12'd3000, 12'd100, 7'd100, 18'd0, 16'd1);
        push_item(make_sample(5'd4, 12'd2000, 8'h06, 1'b1, 1'b0));
        push_item(make_tick());
        push_item(make_tick());
        settle();
        write_reg(CFG_UNUSED, 18'($urandom));
        i_cfg_valid <= 1'b0;
        push_item(make_sample(5'd10, 12'd50, 8'h07, 1'b1, 1'b0));

        // Random phases, each under its own calibration and idling mix.
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            in_gaps_on    = (p % 4) != 0;
            out_stalls_on = (p % 4) != 1;
            case (p)
                0: configure(12'd240,  12'd1807, 7'd5,   18'($urandom), 16'd3);
                1: configure(12'd0,    12'd4000, 7'd100, 18'h3FFFF,     16'd0);
                2: configure(12'd0,    12'd1,    7'd0,   18'($urandom), 16'hFFFF);
                3: configure(12'd3999, 12'd4000, 7'd50,  18'($urandom), 16'd10);
                4: configure(12'hFFF,  12'hFFF,  7'h7F,  18'($urandom), 16'd2);
                5: configure(12'd2000, 12'd1000, 7'd20,  18'($urandom), 16'd5);
                6: configure(12'd100,  12'hFFF,  7'd10,  18'($urandom), 16'd4);
                default: begin
                    mn = 12'($urandom_range(0, 4000));
                    mx = 12'($urandom_range(mn, 4095));
                    configure(mn, mx, 7'($urandom), 18'($urandom),
                              16'($urandom_range(0, 12)));
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        // Silence soak: with the largest timeout a run of ticks keeps the
        // link; a timeout equal to the count drops it on the next tick.
        settle();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        configure(12'd0, 12'd4000, 7'd5, 18'd0, SILENCE_MAX);
        push_item(make_sample(5'd8, 12'd3000, 8'h99, 1'b1, 1'b1));
        repeat (SOAK_TICKS) push_item(make_tick());
        settle();
        write_reg(rcn_pkg::CFG_TIMEOUT, {2'b00, 16'(SOAK_TICKS)});
        i_cfg_valid <= 1'b0;
        push_item(make_tick());
        push_item(make_sample(5'd8, 12'd1000, 8'h98, 1'b1, 1'b0));

        settle();
        if (sb.errors == 0)
            $display("rc_channel_normalizer_top_tb: PASS");
        else
            $display("rc_channel_normalizer_top_tb: FAIL");
        $finish;
    end

endmodule
